// File: design/b2r_pkg.sv
// Shared types, constants, microcode and character tables for the Roman numeral converter.
`timescale 1ns / 1ps

package b2r_pkg;

  localparam int unsigned ValueW  = 12;
  localparam int unsigned SymW    = 7;
  localparam int unsigned PcW     = 4;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned PosW    = 2;
  localparam int unsigned LenW    = 3;
  localparam int unsigned WeightW = 14;  // holds 9 * 1000

  localparam logic [ValueW-1:0] MaxValid = 12'd3999;

  // ASCII codes
  localparam logic [SymW-1:0] SymNone = 7'h00;
  localparam logic [SymW-1:0] SymI    = 7'h49;
  localparam logic [SymW-1:0] SymV    = 7'h56;
  localparam logic [SymW-1:0] SymX    = 7'h58;
  localparam logic [SymW-1:0] SymL    = 7'h4C;
  localparam logic [SymW-1:0] SymC    = 7'h43;
  localparam logic [SymW-1:0] SymD    = 7'h44;
  localparam logic [SymW-1:0] SymM    = 7'h4D;

  // Decimal places
  localparam logic [1:0] PlaceOnes      = 2'd0;
  localparam logic [1:0] PlaceTens      = 2'd1;
  localparam logic [1:0] PlaceHundreds  = 2'd2;
  localparam logic [1:0] PlaceThousands = 2'd3;

  // Microprogram step addresses
  localparam logic [PcW-1:0] PcWait  = 4'd0;
  localparam logic [PcW-1:0] PcErr   = 4'd1;
  localparam logic [PcW-1:0] PcDig3  = 4'd2;
  localparam logic [PcW-1:0] PcEmit3 = 4'd3;
  localparam logic [PcW-1:0] PcDig2  = 4'd4;
  localparam logic [PcW-1:0] PcEmit2 = 4'd5;
  localparam logic [PcW-1:0] PcDig1  = 4'd6;
  localparam logic [PcW-1:0] PcEmit1 = 4'd7;
  localparam logic [PcW-1:0] PcDig0  = 4'd8;
  localparam logic [PcW-1:0] PcEmit0 = 4'd9;

  typedef enum logic [1:0] {
    OP_WAIT,   // take a transaction; range failure falls through, else jump
    OP_ERR,    // emit the error character, then jump
    OP_DIGIT,  // peel one decimal digit off the remainder
    OP_EMIT    // emit the digit's characters, jump when done
  } op_e;

  typedef enum logic [1:0] {
    SEL_UNIT,
    SEL_FIVE,
    SEL_TEN
  } sel_e;

  typedef struct packed {
    op_e            op;
    logic [1:0]     place;
    logic [PcW-1:0] target;
  } ctrl_t;

  // Control store
  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t w;
    case (pc)
      PcWait:  w = '{op: OP_WAIT,  place: PlaceOnes,      target: PcDig3};
      PcErr:   w = '{op: OP_ERR,   place: PlaceOnes,      target: PcWait};
      PcDig3:  w = '{op: OP_DIGIT, place: PlaceThousands, target: PcEmit3};
      PcEmit3: w = '{op: OP_EMIT,  place: PlaceThousands, target: PcDig2};
      PcDig2:  w = '{op: OP_DIGIT, place: PlaceHundreds,  target: PcEmit2};
      PcEmit2: w = '{op: OP_EMIT,  place: PlaceHundreds,  target: PcDig1};
      PcDig1:  w = '{op: OP_DIGIT, place: PlaceTens,      target: PcEmit1};
      PcEmit1: w = '{op: OP_EMIT,  place: PlaceTens,      target: PcDig0};
      PcDig0:  w = '{op: OP_DIGIT, place: PlaceOnes,      target: PcEmit0};
      PcEmit0: w = '{op: OP_EMIT,  place: PlaceOnes,      target: PcWait};
      default: w = '{op: OP_WAIT,  place: PlaceOnes,      target: PcDig3};
    endcase
    return w;
  endfunction

  // k * 10^place
  function automatic logic [WeightW-1:0] dec_weight(input logic [1:0] place,
                                                    input logic [DigitW-1:0] k);
    logic [WeightW-1:0] w;
    case (place)
      PlaceOnes:      w = WeightW'(k);
      PlaceTens:      w = WeightW'(k) * 14'd10;
      PlaceHundreds:  w = WeightW'(k) * 14'd100;
      PlaceThousands: w = WeightW'(k) * 14'd1000;
      default:        w = '0;
    endcase
    return w;
  endfunction

  // Characters per digit
  function automatic logic [LenW-1:0] pat_len(input logic [DigitW-1:0] digit);
    logic [LenW-1:0] n;
    case (digit)
      4'd0:    n = 3'd0;
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Which of unit / five / ten sits at a position in a digit's pattern
  function automatic sel_e pat_sel(input logic [DigitW-1:0] digit,
                                   input logic [PosW-1:0]   pos);
    sel_e s;
    case (digit)
      4'd4:          s = (pos == 2'd0) ? SEL_UNIT : SEL_FIVE;
      4'd9:          s = (pos == 2'd0) ? SEL_UNIT : SEL_TEN;
      4'd5, 4'd6,
      4'd7, 4'd8:    s = (pos == 2'd0) ? SEL_FIVE : SEL_UNIT;
      default:       s = SEL_UNIT;
    endcase
    return s;
  endfunction

  function automatic logic [SymW-1:0] place_char(input logic [1:0] place, input sel_e sel);
    logic [SymW-1:0] c;
    case (place)
      PlaceOnes:      c = (sel == SEL_UNIT) ? SymI : (sel == SEL_FIVE) ? SymV : SymX;
      PlaceTens:      c = (sel == SEL_UNIT) ? SymX : (sel == SEL_FIVE) ? SymL : SymC;
      PlaceHundreds:  c = (sel == SEL_UNIT) ? SymC : (sel == SEL_FIVE) ? SymD : SymM;
      PlaceThousands: c = (sel == SEL_UNIT) ? SymM : SymNone;
      default:        c = SymNone;
    endcase
    return c;
  endfunction

endpackage

// File: design/binary_to_roman_numeral_top.sv
// Binary to Roman numeral converter: microcoded sequencer, output register.
`timescale 1ns / 1ps

// Takes a 12-bit unsigned value per input transaction and returns its subtractive
// Roman numeral as a stream of ASCII characters, one per output transaction,
// thousands first, with last_o set on the final character. Zero and values above
// 3999 give one output transaction with symbol 0, last_o = 1 and error_o = 1.
// A valid value passes one accept step, one digit-extraction step per decimal
// place and one character per cycle while the output is not stalled, all set by
// a ten-step microprogram that drives a single compare/subtract digit unit; a
// numeral has at most 15 characters, for 3888, and a zero digit writes none. An
// out-of-range value passes the accept step and then the error step. in_stall_o
// is low only while the program waits at its first step; the output register
// lets the last character of one value sit unconsumed while the next value is
// taken.

module binary_to_roman_numeral_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [b2r_pkg::ValueW-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [b2r_pkg::SymW-1:0]    symbol_o,
  output logic                        last_o,
  output logic                        error_o
);

  import b2r_pkg::*;

  // sequencer state
  logic [PcW-1:0]    pc_q, pc_d;
  logic              out_valid_q, out_valid_d;

  // datapath registers
  logic [ValueW-1:0] rem_q, rem_d;     // value still to convert
  logic [DigitW-1:0] dig_q, dig_d;     // digit being emitted
  logic [PosW-1:0]   pos_q, pos_d;     // character index within the digit
  logic [SymW-1:0]   sym_q, sym_d;
  logic              last_q, last_d;
  logic              err_q, err_d;

  ctrl_t             ctrl;
  logic              in_fire;
  logic              slot_free;        // output register can take a character
  logic              value_bad;
  logic [DigitW-1:0] ext_digit;
  logic [ValueW-1:0] ext_rem;
  logic [LenW-1:0]   dig_len;
  logic              emit_final;       // this character closes the digit

  assign ctrl       = ucode(pc_q);
  assign in_stall_o = (ctrl.op != OP_WAIT);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign value_bad  = (value_i == '0) || (value_i > MaxValid);

  // Digit unit: count how many multiples of 10^place fit, then subtract them.
  always_comb begin
    ext_digit = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({{(WeightW-ValueW){1'b0}}, rem_q} >= dec_weight(ctrl.place, DigitW'(k))) begin
        ext_digit = DigitW'(k);
      end
    end
    ext_rem = rem_q - ValueW'(dec_weight(ctrl.place, ext_digit));
  end

  assign dig_len    = pat_len(dig_q);
  assign emit_final = (({1'b0, pos_q} + 3'd1) == dig_len);

  // Microcode execution
  always_comb begin
    pc_d        = pc_q;
    out_valid_d = out_valid_q && out_stall_i;
    rem_d       = rem_q;
    dig_d       = dig_q;
    pos_d       = pos_q;
    sym_d       = sym_q;
    last_d      = last_q;
    err_d       = err_q;
    case (ctrl.op)
      OP_WAIT: begin
        if (in_fire) begin
          rem_d = value_i;
          pc_d  = value_bad ? pc_q + 1'b1 : ctrl.target;
        end
      end
      OP_ERR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          sym_d       = SymNone;
          last_d      = 1'b1;
          err_d       = 1'b1;
          pc_d        = ctrl.target;
        end
      end
      OP_DIGIT: begin
        dig_d = ext_digit;
        rem_d = ext_rem;
        pos_d = '0;
        pc_d  = ctrl.target;
      end
      OP_EMIT: begin
        if (dig_len == '0) begin
          pc_d = ctrl.target;  // zero digit: nothing to write
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          sym_d       = place_char(ctrl.place, pat_sel(dig_q, pos_q));
          err_d       = 1'b0;
          // lower places already zero means this is the numeral's end
          last_d      = emit_final && (rem_q == '0);
          pos_d       = pos_q + 1'b1;
          if (emit_final) begin
            pc_d = ctrl.target;
          end
        end
      end
      default: begin
        pc_d = PcWait;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcWait;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dig_q  <= dig_d;
    pos_q  <= pos_d;
    sym_q  <= sym_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = sym_q;
  assign last_o      = last_q;
  assign error_o     = err_q;

endmodule

// File: test/binary_to_roman_numeral_top_tb.sv
// Self-checking testbench for the binary to Roman numeral converter.
`timescale 1ns / 1ps

module binary_to_roman_numeral_top_tb;
  import b2r_pkg::*;

  localparam int unsigned RandomItems   = 250;
  localparam int unsigned QuietTail     = 50;   // final items with no idling on either side
  localparam int unsigned HoldOffAt     = 60;   // item index that starts the long output hold-off
  localparam int unsigned DrainAt       = 120;  // item index where the sender waits for all output
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned ReportLimit   = 10;

  // One output character as the block presents it.
  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last;
    logic            error;
  } roman_char_t;

  // Directed row: a value, and when the outcome is a single obvious character,
  // that character typed in; otherwise the predictor works it out.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              typed;
    roman_char_t       want;
  } directed_row_t;

  localparam int unsigned DirectedRows = 24;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ValueW-1:0]   value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [SymW-1:0]     symbol_o;
  logic                last_o;
  logic                error_o;

  roman_char_t         numeral_q[$];    // characters still owed by the block, oldest first
  roman_char_t         oldest_char;
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count;
  logic                quiet_tail;      // no idling on either side once set
  logic                hold_off_req;    // asks the receiver for one long hold-off

  directed_row_t directed_rows [DirectedRows] = '{
    // out-of-range values: one error character
    '{12'd0,    1'b1, '{SymNone, 1'b1, 1'b1}},
    '{12'd4000, 1'b1, '{SymNone, 1'b1, 1'b1}},
    '{12'd4095, 1'b1, '{SymNone, 1'b1, 1'b1}},
    // single-character numerals, one per Roman letter
    '{12'd1,    1'b1, '{SymI, 1'b1, 1'b0}},
    '{12'd5,    1'b1, '{SymV, 1'b1, 1'b0}},
    '{12'd10,   1'b1, '{SymX, 1'b1, 1'b0}},
    '{12'd50,   1'b1, '{SymL, 1'b1, 1'b0}},
    '{12'd100,  1'b1, '{SymC, 1'b1, 1'b0}},
    '{12'd500,  1'b1, '{SymD, 1'b1, 1'b0}},
    '{12'd1000, 1'b1, '{SymM, 1'b1, 1'b0}},
    // top of range, longest numeral, subtractive forms, bit patterns
    '{12'd3999, 1'b0, '0},
    '{12'd3888, 1'b0, '0},
    '{12'd4,    1'b0, '0},
    '{12'd9,    1'b0, '0},
    '{12'd40,   1'b0, '0},
    '{12'd90,   1'b0, '0},
    '{12'd400,  1'b0, '0},
    '{12'd900,  1'b0, '0},
    '{12'd2048, 1'b0, '0},
    '{12'd1365, 1'b0, '0},
    '{12'd2730, 1'b0, '0},
    '{12'd3000, 1'b0, '0},
    '{12'd14,   1'b0, '0},
    '{12'd3,    1'b0, '0}
  };

  binary_to_roman_numeral_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .symbol_o    (symbol_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Expected characters of one value's numeral, appended to numeral_q.
  function automatic void predict_numeral(input logic [ValueW-1:0] value);
    int unsigned     digit;
    int unsigned     scale;
    logic [SymW-1:0] unit_sym;
    logic [SymW-1:0] five_sym;
    logic [SymW-1:0] ten_sym;
    if (value == 0 || value > MaxValid) begin
      numeral_q.push_back('{SymNone, 1'b1, 1'b1});
      return;
    end
    scale = 1000;
    for (int place = 3; place >= 0; place--) begin
      digit = (int'(value) / scale) % 10;
      case (place)
        0: begin unit_sym = SymI; five_sym = SymV; ten_sym = SymX; end
        1: begin unit_sym = SymX; five_sym = SymL; ten_sym = SymC; end
        2: begin unit_sym = SymC; five_sym = SymD; ten_sym = SymM; end
        default: begin unit_sym = SymM; five_sym = SymNone; ten_sym = SymNone; end
      endcase
      if (place == 3) begin
        // thousands: plain repetition of M
        repeat (digit) numeral_q.push_back('{unit_sym, 1'b0, 1'b0});
      end else if (digit == 9) begin
        numeral_q.push_back('{unit_sym, 1'b0, 1'b0});
        numeral_q.push_back('{ten_sym, 1'b0, 1'b0});
      end else if (digit == 4) begin
        numeral_q.push_back('{unit_sym, 1'b0, 1'b0});
        numeral_q.push_back('{five_sym, 1'b0, 1'b0});
      end else begin
        if (digit >= 5) begin
          numeral_q.push_back('{five_sym, 1'b0, 1'b0});
          digit -= 5;
        end
        repeat (digit) numeral_q.push_back('{unit_sym, 1'b0, 1'b0});
      end
      scale = scale / 10;
    end
    numeral_q[numeral_q.size() - 1].last = 1'b1;
  endfunction

  // Offer one value, starting at a falling edge; returns at the falling edge after
  // acceptance with valid still high, so a back-to-back value keeps it up.
  task automatic offer_value(input logic [ValueW-1:0] value, input logic typed,
                             input roman_char_t want);
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    if (typed) numeral_q.push_back(want);
    else predict_numeral(value);
    @(negedge clk_i);
  endtask

  // Random sender gap, skipped in the quiet tail.
  task automatic sender_gap();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
  endtask

  // Receiver: short random stall bursts, plus one long hold-off on request.
  initial begin
    int unsigned held;
    logic        held_off;
    out_stall_i = 1'b0;
    held_off    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !held_off) begin
        out_stall_i <= 1'b1;
        for (held = 0; held < HoldOffCycles; held++) @(negedge clk_i);
        out_stall_i <= 1'b0;
        held_off = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Output check: every accepted character against the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (numeral_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("unexpected character: symbol %h last %b error %b",
                   symbol_o, last_o, error_o);
      end else begin
        oldest_char = numeral_q.pop_front();
        if (symbol_o !== oldest_char.symbol || last_o !== oldest_char.last ||
            error_o !== oldest_char.error) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("character mismatch: expected symbol %h last %b error %b, got %h %b %b",
                     oldest_char.symbol, oldest_char.last, oldest_char.error,
                     symbol_o, last_o, error_o);
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("binary_to_roman_numeral_top_tb failed");
    $finish;
  end

  // Stimulus: directed table, then random values, then drain and verdict.
  initial begin
    logic [ValueW-1:0] value;
    int unsigned       pick;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    value_i        = '0;
    quiet_tail     = 1'b0;
    hold_off_req   = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      sender_gap();
      offer_value(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == HoldOffAt) hold_off_req = 1'b1;   // sender keeps offering meanwhile
      if (n == DrainAt) begin
        // pause until the block has handed over every owed character
        in_valid_i <= 1'b0;
        while (numeral_q.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
      if (n == RandomItems - QuietTail) quiet_tail = 1'b1;
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        value = ValueW'($urandom_range(1, MaxValid));
      end else if (pick < 15) begin
        // digit by digit, so long numerals such as 3888 come up often
        value = ValueW'($urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100 +
                        $urandom_range(0, 9) * 10 + $urandom_range(0, 9));
      end else if (pick < 17) begin
        value = ValueW'($urandom_range(MaxValid + 1, 4095));
      end else if (pick < 18) begin
        value = '0;
      end else begin
        value = ValueW'($urandom);
      end
      sender_gap();
      offer_value(value, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (numeral_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("binary_to_roman_numeral_top_tb passed");
    else
      $display("binary_to_roman_numeral_top_tb failed");
    $finish;
  end

endmodule
